// File: hdl/aesd_pkg.sv
// ---------------------------------------------------------------------------
// aesd_pkg: shared types and constants
// Sizes, result kinds, register indexes, reset defaults, control characters and the argument stack command struct.
// ---------------------------------------------------------------------------
package aesd_pkg;

   localparam int ARG_SLOTS = 16;
   localparam int IDX_W     = $clog2(ARG_SLOTS);

   // result kinds
   localparam logic [4:0] KIND_GLYPH      = 5'd0;
   localparam logic [4:0] KIND_UP         = 5'd1;
   localparam logic [4:0] KIND_DOWN       = 5'd2;
   localparam logic [4:0] KIND_RIGHT      = 5'd3;
   localparam logic [4:0] KIND_LEFT       = 5'd4;
   localparam logic [4:0] KIND_LINE_DOWN  = 5'd5;
   localparam logic [4:0] KIND_LINE_UP    = 5'd6;
   localparam logic [4:0] KIND_COLUMN     = 5'd7;
   localparam logic [4:0] KIND_POSITION   = 5'd8;
   localparam logic [4:0] KIND_ERASE_DISP = 5'd9;
   localparam logic [4:0] KIND_ERASE_LINE = 5'd10;
   localparam logic [4:0] KIND_ERASE_CHAR = 5'd11;
   localparam logic [4:0] KIND_CPR        = 5'd12;
   localparam logic [4:0] KIND_DSR        = 5'd13;
   localparam logic [4:0] KIND_DA         = 5'd14;
   localparam logic [4:0] KIND_MODE       = 5'd15;
   localparam logic [4:0] KIND_TITLE_BEG  = 5'd16;
   localparam logic [4:0] KIND_TITLE_CHR  = 5'd17;
   localparam logic [4:0] KIND_TITLE_END  = 5'd18;

   // register indexes
   localparam logic CSR_DEFAULT_FORE = 1'b0;
   localparam logic CSR_DEFAULT_BACK = 1'b1;

   localparam logic [3:0] DEFAULT_FORE_RST = 4'd7;
   localparam logic [3:0] DEFAULT_BACK_RST = 4'd0;

   localparam logic [7:0] CHR_ESC = 8'h1B;
   localparam logic [7:0] CHR_BEL = 8'h07;

   typedef logic [8:0] colour_type;

   typedef struct packed {
      logic       clear;
      logic       digit;
      logic       sep;
      logic [3:0] digit_val;
   } arg_cmd_type;

endpackage

// File: hdl/ansi_escape_sequence_decoder_top.sv
// ---------------------------------------------------------------------------
// ansi_escape_sequence_decoder_top: terminal byte stream decoder
// UTF-8 glyph decoding, ESC/CSI/private/OSC parsing and SGR colour tracking.
// ---------------------------------------------------------------------------
// Usage:
//   req_ channel carries one program output byte per transaction. rsp_ channel
//   returns at most one result per byte (glyph or display command). csr_ port
//   writes default_fore (index 0) and default_back (index 1); csr_ready is
//   always high, write only while idle.
// Output: a result is registered and shows on rsp_ in the cycle after its byte.
// Throughput: one byte per cycle for all bytes except an SGR final ('m'),
//   after which the sequencer walks the argument stack one slot per cycle
//   through a single shared slot compare unit and then ends the walk.
//   req_stall is high during the walk.
// A byte is also held off while a finished result waits under rsp_stall.
// Reset: parser returns to normal text, argument stack is emptied, colours
//   return to 7 on 0 and the default registers to their reset values.
// ---------------------------------------------------------------------------
module ansi_escape_sequence_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_kind,
   output logic [15:0] rsp_arg_a,
   output logic [15:0] rsp_arg_b,
   output logic [20:0] rsp_codepoint,
   output logic [8:0]  rsp_fore,
   output logic [8:0]  rsp_back,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [3:0]  csr_data
);
   import aesd_pkg::*;

   localparam logic [2:0] M_NORMAL = 3'd0;
   localparam logic [2:0] M_ESC    = 3'd1;
   localparam logic [2:0] M_ATTR   = 3'd2;
   localparam logic [2:0] M_PRIV   = 3'd3;
   localparam logic [2:0] M_OSC    = 3'd4;
   localparam logic [2:0] M_TITLE  = 3'd5;
   localparam logic [2:0] M_STREND = 3'd6;
   localparam logic [2:0] M_IGNORE = 3'd7;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_EXT1 = 2'd2;
   localparam logic [1:0] S_EXT2 = 2'd3;

   logic [3:0]       dfore_ff, dback_ff;
   logic [2:0]       mode_ff, mode_in;
   logic             title_ff, title_in;
   colour_type       fore_ff, fore_in, back_ff, back_in;
   logic [1:0]       uleft_ff, uleft_in;
   logic [20:0]      uacc_ff, uacc_in;
   logic [1:0]       seq_ff, seq_in;
   logic [1:0]       seq_in_next;
   logic [IDX_W:0]   widx_ff, widx_in;
   logic             wback_ff, wback_in;

   logic             rv_ff;
   logic [4:0]       kind_ff, kind_in;
   logic [15:0]      a_ff, a_in, b_ff, b_in;
   logic [20:0]      cp_ff, cp_in;
   colour_type       of_ff, of_in, ob_ff, ob_in;
   logic             emit;

   arg_cmd_type      cmd;
   logic [15:0]      rd_val, slot0, slot1, slot1_eff, cnt0, pos0, pos1;
   logic [IDX_W-1:0] aidx, sep_idx;
   logic             accept, c_digit;
   logic [7:0]       c;
   logic [3:0]       hi, cb;
   colour_type       dfore9, dback9;

   aesd_args u_args (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .rd_idx (widx_ff[IDX_W-1:0]),
      .rd_val (rd_val),
      .idx    (aidx),
      .slot0  (slot0),
      .slot1  (slot1)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (seq_ff != S_IDLE) || (rv_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign c         = req_data_byte;
   assign hi        = c[7:4];
   assign c_digit   = (c >= 8'h30) && (c <= 8'h39);
   assign dfore9    = {5'd0, dfore_ff};
   assign dback9    = {5'd0, dback_ff};

   // argument views after the separator that a final byte pushes
   assign sep_idx   = (aidx == IDX_W'(ARG_SLOTS - 1)) ? aidx : aidx + 1'b1;
   assign slot1_eff = (sep_idx == IDX_W'(1)) ? 16'd0 : slot1;
   assign cnt0      = (slot0 == 16'd0) ? 16'd1 : slot0;
   assign pos0      = (slot0 == 16'd0) ? 16'd0 : slot0 - 16'd1;
   assign pos1      = (slot1_eff == 16'd0) ? 16'd0 : slot1_eff - 16'd1;

   // byte decode
   always_comb begin
      mode_in  = mode_ff;
      title_in = title_ff;
      uleft_in = uleft_ff;
      uacc_in  = uacc_ff;
      emit     = 1'b0;
      kind_in  = KIND_GLYPH;
      a_in     = '0;
      b_in     = '0;
      cp_in    = '0;
      of_in    = '0;
      ob_in    = '0;
      cmd      = '0;
      cmd.digit_val = c[3:0];
      seq_in   = S_IDLE;
      if (accept) begin
         unique case (mode_ff)
            M_NORMAL: begin
               if (c == CHR_ESC) begin
                  mode_in   = M_ESC;
                  cmd.clear = 1'b1;
               end else if (uleft_ff == 2'd0) begin
                  if (hi == 4'hC || hi == 4'hD) begin
                     uleft_in = 2'd1;
                     uacc_in  = {10'd0, c[4:0], 6'd0};
                  end else if (hi == 4'hE) begin
                     uleft_in = 2'd2;
                     uacc_in  = {5'd0, c[3:0], 12'd0};
                  end else if (hi == 4'hF) begin
                     uleft_in = 2'd3;
                     uacc_in  = {c[2:0], 18'd0};
                  end else begin
                     emit  = 1'b1;
                     cp_in = {13'd0, c};
                     of_in = fore_ff;
                     ob_in = back_ff;
                  end
               end else begin
                  uleft_in = uleft_ff - 2'd1;
                  case (uleft_in)
                     2'd0:    uacc_in = uacc_ff | {15'd0, c[5:0]};
                     2'd1:    uacc_in = uacc_ff | {9'd0, c[5:0], 6'd0};
                     default: uacc_in = uacc_ff | {3'd0, c[5:0], 12'd0};
                  endcase
                  if (uleft_in == 2'd0) begin
                     emit  = 1'b1;
                     cp_in = uacc_in;
                     of_in = fore_ff;
                     ob_in = back_ff;
                  end
               end
            end
            M_ESC: begin
               mode_in = M_NORMAL;
               if (c == "[") begin
                  mode_in = M_ATTR;
               end else if (c == "]") begin
                  mode_in = M_OSC;
               end else if (c == ">" || c == "=") begin
                  emit    = 1'b1;
                  kind_in = KIND_MODE;
                  b_in    = (c == "=") ? 16'd1 : 16'd0;
               end
            end
            M_ATTR, M_PRIV, M_OSC: begin
               if (c == "?") begin
                  mode_in = M_PRIV;
               end else if (c_digit) begin
                  cmd.digit = 1'b1;
               end else begin
                  cmd.sep = 1'b1;
                  mode_in = M_NORMAL;
                  if (mode_ff == M_ATTR) begin
                     mode_in = (c == ";") ? M_ATTR : M_NORMAL;
                     a_in    = cnt0;
                     case (c)
                        "A": begin emit = 1'b1; kind_in = KIND_UP; end
                        "B": begin emit = 1'b1; kind_in = KIND_DOWN; end
                        "C": begin emit = 1'b1; kind_in = KIND_RIGHT; end
                        "D": begin emit = 1'b1; kind_in = KIND_LEFT; end
                        "E": begin emit = 1'b1; kind_in = KIND_LINE_DOWN; end
                        "F": begin emit = 1'b1; kind_in = KIND_LINE_UP; end
                        "G": begin emit = 1'b1; kind_in = KIND_COLUMN; a_in = pos0; end
                        "H", "f": begin
                           emit    = 1'b1;
                           kind_in = KIND_POSITION;
                           a_in    = pos0;
                           b_in    = pos1;
                        end
                        "J", "K": begin
                           emit    = (slot0 <= 16'd2);
                           kind_in = (c == "J") ? KIND_ERASE_DISP : KIND_ERASE_LINE;
                           a_in    = slot0;
                        end
                        "X": begin
                           emit    = 1'b1;
                           kind_in = KIND_ERASE_CHAR;
                           of_in   = dfore9;
                           ob_in   = dback9;
                        end
                        "m": seq_in = S_WALK;
                        "n": begin
                           emit    = (slot0 == 16'd6) || (slot0 == 16'd5);
                           kind_in = (slot0 == 16'd6) ? KIND_CPR : KIND_DSR;
                           a_in    = '0;
                        end
                        "c": begin emit = 1'b1; kind_in = KIND_DA; a_in = '0; end
                        "%": mode_in = M_IGNORE;
                        default: ;
                     endcase
                     if (!emit) begin
                        a_in    = '0;
                        kind_in = KIND_GLYPH;
                     end
                  end else if (mode_ff == M_PRIV) begin
                     if (c == "$") begin
                        mode_in = M_IGNORE;
                     end else if (c == "h" || c == "l") begin
                        emit    = 1'b1;
                        kind_in = KIND_MODE;
                        b_in    = (c == "h") ? 16'd1 : 16'd0;
                        if (slot0 == 16'd25)        a_in = 16'd1;
                        else if (slot0 == 16'd2004) a_in = 16'd2;
                        else if (slot0 == 16'd7)    a_in = 16'd3;
                        else if (slot0 == 16'd1004) a_in = 16'd4;
                        else begin
                           emit    = 1'b0;
                           kind_in = KIND_GLYPH;
                           b_in    = '0;
                        end
                     end
                  end else begin
                     mode_in  = M_TITLE;
                     title_in = (slot0 == 16'd0);
                     emit     = title_in;
                     kind_in  = title_in ? KIND_TITLE_BEG : KIND_GLYPH;
                  end
               end
            end
            M_TITLE: begin
               if (c == CHR_ESC || c == CHR_BEL) begin
                  mode_in  = (c == CHR_ESC) ? M_STREND : M_NORMAL;
                  title_in = 1'b0;
                  emit     = title_ff;
                  kind_in  = title_ff ? KIND_TITLE_END : KIND_GLYPH;
               end else if (title_ff) begin
                  emit    = 1'b1;
                  kind_in = KIND_TITLE_CHR;
                  a_in    = {8'd0, c};
               end
            end
            default: mode_in = M_NORMAL;
         endcase
      end
   end

   // SGR sequencer: one stack slot per cycle through one compare unit
   always_comb begin
      fore_in  = fore_ff;
      back_in  = back_ff;
      widx_in  = widx_ff;
      wback_in = wback_ff;
      cb       = rd_val[3:0] - 4'd4;
      unique case (seq_ff)
         S_IDLE: begin
            widx_in = '0;
            if (seq_in == S_WALK) begin
               widx_in = '0;
            end
         end
         S_WALK: begin
            widx_in = widx_ff + 1'b1;
            if (rd_val == 16'd0) begin
               fore_in = dfore9;
               back_in = dback9;
            end else if (rd_val >= 16'd30 && rd_val <= 16'd37) begin
               fore_in = colour_type'(rd_val - 16'd30);
            end else if (rd_val >= 16'd40 && rd_val <= 16'd47) begin
               back_in = colour_type'(rd_val - 16'd40);
            end else if (rd_val == 16'd39) begin
               fore_in = dfore9;
            end else if (rd_val == 16'd49) begin
               back_in = dback9;
            end else if (rd_val == 16'd38 || rd_val == 16'd48) begin
               wback_in = (rd_val == 16'd48);
            end else if (rd_val >= 16'd90 && rd_val <= 16'd97) begin
               fore_in = colour_type'(rd_val - 16'd90) | 9'd8;
            end else if (rd_val >= 16'd100 && rd_val <= 16'd107) begin
               cb      = rd_val[3:0] - 4'd4;
               back_in = {5'd0, cb};
               if ({5'd0, cb} != dback9) begin
                  back_in = {5'd0, cb} | 9'd8;
               end
            end else if (rd_val == 16'd22) begin
               fore_in = fore_ff & 9'd7;
               back_in = back_ff & 9'd7;
            end
         end
         S_EXT1: widx_in = widx_ff + 1'b1;
         default: begin
            widx_in = widx_ff + 1'b1;
            if (rd_val <= 16'd255) begin
               if (wback_ff) back_in = colour_type'(rd_val + 16'd16);
               else          fore_in = colour_type'(rd_val + 16'd16);
            end
         end
      endcase
   end

   // sequencer next state
   logic ext_ok, walk_done;
   assign ext_ok    = widx_ff < (IDX_W + 1)'(ARG_SLOTS - 1);
   assign walk_done = widx_ff >= {1'b0, aidx};
   always_comb begin
      seq_in_next = seq_ff;
      unique case (seq_ff)
         S_IDLE: seq_in_next = seq_in;
         S_WALK: begin
            if (walk_done) begin
               seq_in_next = S_IDLE;
            end else if ((rd_val == 16'd38 || rd_val == 16'd48) && ext_ok) begin
               seq_in_next = S_EXT1;
            end
         end
         S_EXT1: seq_in_next = (rd_val == 16'd5 && ext_ok) ? S_EXT2 : S_WALK;
         default: seq_in_next = S_WALK;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dfore_ff <= DEFAULT_FORE_RST;
         dback_ff <= DEFAULT_BACK_RST;
         mode_ff  <= M_NORMAL;
         title_ff <= 1'b0;
         fore_ff  <= {5'd0, DEFAULT_FORE_RST};
         back_ff  <= {5'd0, DEFAULT_BACK_RST};
         uleft_ff <= '0;
         uacc_ff  <= '0;
         seq_ff   <= S_IDLE;
         widx_ff  <= '0;
         wback_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DEFAULT_FORE) dfore_ff <= csr_data;
            if (csr_index == CSR_DEFAULT_BACK) dback_ff <= csr_data;
         end
         mode_ff  <= mode_in;
         title_ff <= title_in;
         uleft_ff <= uleft_in;
         uacc_ff  <= uacc_in;
         seq_ff   <= (seq_ff == S_WALK && walk_done) ? S_IDLE : seq_in_next;
         widx_ff  <= (seq_ff == S_WALK && walk_done) ? widx_ff : widx_in;
         wback_ff <= wback_in;
         if (!(seq_ff == S_WALK && walk_done)) begin
            fore_ff <= fore_in;
            back_ff <= back_in;
         end
         if (accept && emit)  rv_ff <= 1'b1;
         else if (!rsp_stall) rv_ff <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff <= kind_in;
         a_ff    <= a_in;
         b_ff    <= b_in;
         cp_ff   <= cp_in;
         of_ff   <= of_in;
         ob_ff   <= ob_in;
      end
   end

   assign rsp_valid     = rv_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_arg_a     = a_ff;
   assign rsp_arg_b     = b_ff;
   assign rsp_codepoint = cp_ff;
   assign rsp_fore      = of_ff;
   assign rsp_back      = ob_ff;

endmodule

// File: hdl/aesd_args.sv
// ---------------------------------------------------------------------------
// aesd_args: argument stack
// Decimal accumulation with saturation, separator push and one read port.
// ---------------------------------------------------------------------------
module aesd_args (
   input  logic                      clock,
   input  logic                      reset,
   input  aesd_pkg::arg_cmd_type     cmd,
   input  logic [aesd_pkg::IDX_W-1:0] rd_idx,
   output logic [15:0]               rd_val,
   output logic [aesd_pkg::IDX_W-1:0] idx,
   output logic [15:0]               slot0,
   output logic [15:0]               slot1
);
   import aesd_pkg::*;

   logic [15:0]          val_ff [ARG_SLOTS];
   logic [ARG_SLOTS-1:0] blank_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [15:0]          acc_ff;
   logic [19:0]          prod;
   logic [15:0]          acc_in;
   logic [IDX_W-1:0]     sep_idx;

   // multiply-accumulate one decimal digit, saturate at 65535
   assign prod   = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} + {16'd0, cmd.digit_val};
   assign acc_in = (prod > 20'd65535) ? 16'hFFFF : prod[15:0];

   assign sep_idx = (idx_ff == IDX_W'(ARG_SLOTS - 1)) ? idx_ff : idx_ff + 1'b1;

   // control state: blank marks, index and running value
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         blank_ff <= '1;
         idx_ff   <= '0;
         acc_ff   <= '0;
      end else if (cmd.digit) begin
         blank_ff[idx_ff] <= 1'b0;
         acc_ff           <= acc_in;
      end else if (cmd.sep) begin
         idx_ff            <= sep_idx;
         blank_ff[sep_idx] <= 1'b1;
         acc_ff            <= '0;
      end
   end

   // slot values
   always_ff @(posedge clock) begin
      if (!cmd.clear) begin
         if (cmd.digit) begin
            val_ff[idx_ff] <= acc_in;
         end else if (cmd.sep) begin
            val_ff[sep_idx] <= '0;
         end
      end
   end

   // a blank slot reads as zero
   assign rd_val = blank_ff[rd_idx] ? 16'd0 : val_ff[rd_idx];
   assign slot0  = blank_ff[0] ? 16'd0 : val_ff[0];
   assign slot1  = blank_ff[1] ? 16'd0 : val_ff[1];
   assign idx    = idx_ff;

endmodule

// File: hdl/aesd_checker.sv
// ---------------------------------------------------------------------------
// aesd_checker: port-level checks
// Result channel holding and field rules of the decoder results.
// ---------------------------------------------------------------------------
module aesd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [4:0]  rsp_kind,
   input logic [20:0] rsp_codepoint,
   input logic [8:0]  rsp_fore,
   input logic [8:0]  rsp_back
);
   import aesd_pkg::*;

   // hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind))
      else $error("stalled result dropped");

   // only glyphs carry a codepoint
   a_cp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_GLYPH |-> rsp_codepoint == 21'd0)
      else $error("codepoint on a command");

   // colours only on glyphs and erase chars
   a_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_GLYPH && rsp_kind != KIND_ERASE_CHAR
      |-> rsp_fore == 9'd0 && rsp_back == 9'd0)
      else $error("colour on a command");

   // erase chars colours come from four-bit defaults
   a_ech: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERASE_CHAR |-> rsp_fore < 9'd16 && rsp_back < 9'd16)
      else $error("erase colour out of range");

endmodule

bind ansi_escape_sequence_decoder_top aesd_checker u_aesd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_kind      (rsp_kind),
   .rsp_codepoint (rsp_codepoint),
   .rsp_fore      (rsp_fore),
   .rsp_back      (rsp_back)
);

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb: byte stream check of the terminal escape sequence decoder
// Feeds program output bytes (directed sequences, then random well-formed
// escape sequences, UTF-8 text and noise), predicts every glyph and display
// command, and compares each response transaction field by field.
// ---------------------------------------------------------------------------
module tb;
   import aesd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_SLOTS = ARG_SLOTS;

   typedef enum logic [2:0] {
      PM_NORMAL, PM_ESC, PM_ATTR, PM_PRIV, PM_OSC, PM_TITLE, PM_STREND, PM_IGNORE
   } parse_mode_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] arg_a;
      logic [15:0] arg_b;
      logic [20:0] codepoint;
      logic [8:0]  fore;
      logic [8:0]  back;
   } term_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_kind;
   logic [15:0] rsp_arg_a, rsp_arg_b;
   logic [20:0] rsp_codepoint;
   logic [8:0]  rsp_fore, rsp_back;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [3:0]  csr_data = '0;

   ansi_escape_sequence_decoder_top u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder model state
   parse_mode_type pmode;
   logic [15:0]    slot_val [N_SLOTS];
   logic           slot_blank [N_SLOTS];
   int             slot_idx;
   logic           title_on;
   logic [8:0]     fore_now, back_now;
   logic [3:0]     dflt_fore, dflt_back;
   int             u8_left;
   logic [20:0]    u8_acc;

   term_cmd_type cmd_expected [$];
   logic [7:0]   byte_queue [$];
   int           n_errors = 0;
   int           n_cmds = 0;
   int           n_bytes = 0;
   bit           idle_enable = 1'b1;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
      $display("mismatch %s: got %0d expected %0d (response %0d)", what, got, exp, n_cmds);
      n_errors++;
   endtask

   function automatic void stack_clear();
      for (int i = 0; i < N_SLOTS; i++) begin
         slot_val[i] = '0;
         slot_blank[i] = 1'b1;
      end
      slot_idx = 0;
   endfunction

   function automatic void model_reset();
      dflt_fore = DEFAULT_FORE_RST;
      dflt_back = DEFAULT_BACK_RST;
      pmode = PM_NORMAL;
      stack_clear();
      title_on = 1'b0;
      fore_now = {5'd0, dflt_fore};
      back_now = {5'd0, dflt_back};
      u8_left = 0;
      u8_acc = '0;
   endfunction

   function automatic void push_cmd(input logic [4:0] k, input int a, input int b,
                                    input int cp, input int f, input int bk);
      term_cmd_type c;
      c.kind = k;
      c.arg_a = a[15:0];
      c.arg_b = b[15:0];
      c.codepoint = cp[20:0];
      c.fore = f[8:0];
      c.back = bk[8:0];
      cmd_expected.push_back(c);
   endfunction

   function automatic int count_of(input int k);
      return (slot_blank[k] || slot_val[k] == 0) ? 1 : int'(slot_val[k]);
   endfunction

   function automatic int pos_of(input int k);
      return (slot_blank[k] || slot_val[k] == 0) ? 0 : int'(slot_val[k]) - 1;
   endfunction

   function automatic void apply_sgr();
      int i;
      int a;
      i = 0;
      while (i < slot_idx) begin
         a = slot_val[i];
         if (slot_blank[i] || a == 0) begin
            fore_now = {5'd0, dflt_fore};
            back_now = {5'd0, dflt_back};
         end else if (a >= 30 && a <= 37) begin
            fore_now = 9'(a - 30);
         end else if (a >= 40 && a <= 47) begin
            back_now = 9'(a - 40);
         end else if (a == 39) begin
            fore_now = {5'd0, dflt_fore};
         end else if (a == 49) begin
            back_now = {5'd0, dflt_back};
         end else if (a == 38 || a == 48) begin
            if (i < N_SLOTS - 1) begin
               i++;
               if (slot_val[i] == 5 && i < N_SLOTS - 1) begin
                  i++;
                  if (slot_val[i] <= 255) begin
                     if (a == 38) fore_now = 9'(slot_val[i] + 16);
                     else back_now = 9'(slot_val[i] + 16);
                  end
               end
            end
         end else if (a >= 90 && a <= 97) begin
            fore_now = 9'((a - 90) | 8);
         end else if (a >= 100 && a <= 107) begin
            back_now = 9'(a - 100);
            if (back_now != {5'd0, dflt_back}) back_now = back_now | 9'd8;
         end else if (a == 22) begin
            fore_now = fore_now & 9'd7;
            back_now = back_now & 9'd7;
         end
         i++;
      end
   endfunction

   function automatic void csi_final(input logic [7:0] c);
      pmode = PM_NORMAL;
      case (c)
         "A": push_cmd(KIND_UP, count_of(0), 0, 0, 0, 0);
         "B": push_cmd(KIND_DOWN, count_of(0), 0, 0, 0, 0);
         "C": push_cmd(KIND_RIGHT, count_of(0), 0, 0, 0, 0);
         "D": push_cmd(KIND_LEFT, count_of(0), 0, 0, 0, 0);
         "E": push_cmd(KIND_LINE_DOWN, count_of(0), 0, 0, 0, 0);
         "F": push_cmd(KIND_LINE_UP, count_of(0), 0, 0, 0, 0);
         "G": push_cmd(KIND_COLUMN, pos_of(0), 0, 0, 0, 0);
         "H", "f": push_cmd(KIND_POSITION, pos_of(0), pos_of(1), 0, 0, 0);
         "J", "K": begin
            if (slot_val[0] <= 2)
               push_cmd(c == "J" ? KIND_ERASE_DISP : KIND_ERASE_LINE, slot_val[0], 0, 0, 0, 0);
         end
         "X": push_cmd(KIND_ERASE_CHAR, count_of(0), 0, 0, dflt_fore, dflt_back);
         "m": apply_sgr();
         "n": begin
            if (slot_val[0] == 6) push_cmd(KIND_CPR, 0, 0, 0, 0, 0);
            else if (slot_val[0] == 5) push_cmd(KIND_DSR, 0, 0, 0, 0, 0);
         end
         "c": push_cmd(KIND_DA, 0, 0, 0, 0, 0);
         "%": pmode = PM_IGNORE;
         default: ;
      endcase
   endfunction

   function automatic void private_final(input logic [7:0] c);
      int id;
      pmode = PM_NORMAL;
      if (c == "$") begin
         pmode = PM_IGNORE;
         return;
      end
      if (c != "h" && c != "l") return;
      case (int'(slot_val[0]))
         25: id = 1;
         2004: id = 2;
         7: id = 3;
         1004: id = 4;
         default: return;
      endcase
      push_cmd(KIND_MODE, id, c == "h" ? 1 : 0, 0, 0, 0);
   endfunction

   function automatic void decode_text(input logic [7:0] c);
      if (u8_left == 0) begin
         case (c[7:4])
            4'hC, 4'hD: begin u8_left = 1; u8_acc = 21'(c[4:0]) << 6; end
            4'hE: begin u8_left = 2; u8_acc = 21'(c[3:0]) << 12; end
            4'hF: begin u8_left = 3; u8_acc = 21'(c[2:0]) << 18; end
            default: push_cmd(KIND_GLYPH, 0, 0, c, fore_now, back_now);
         endcase
         return;
      end
      u8_left--;
      u8_acc = u8_acc | (21'(c[5:0]) << (6 * u8_left));
      if (u8_left == 0) push_cmd(KIND_GLYPH, 0, 0, u8_acc, fore_now, back_now);
   endfunction

   // predict the response (if any) to one accepted byte
   function automatic void decode_byte(input logic [7:0] c);
      int v;
      case (pmode)
         PM_NORMAL: begin
            if (c == CHR_ESC) begin
               pmode = PM_ESC;
               stack_clear();
            end else decode_text(c);
         end
         PM_ESC: begin
            pmode = PM_NORMAL;
            if (c == "[") pmode = PM_ATTR;
            else if (c == "]") pmode = PM_OSC;
            else if (c == ">") push_cmd(KIND_MODE, 0, 0, 0, 0, 0);
            else if (c == "=") push_cmd(KIND_MODE, 0, 1, 0, 0, 0);
         end
         PM_ATTR, PM_PRIV, PM_OSC: begin
            if (c == "?") pmode = PM_PRIV;
            else if (c >= "0" && c <= "9") begin
               v = int'(slot_val[slot_idx]) * 10 + int'(c - "0");
               slot_val[slot_idx] = v > 65535 ? 16'hFFFF : 16'(v);
               slot_blank[slot_idx] = 1'b0;
            end else begin
               if (slot_idx < N_SLOTS - 1) slot_idx++;
               slot_val[slot_idx] = '0;
               slot_blank[slot_idx] = 1'b1;
               if (pmode == PM_ATTR) begin
                  if (c != ";") csi_final(c);
               end else if (pmode == PM_PRIV) private_final(c);
               else begin
                  pmode = PM_TITLE;
                  title_on = (slot_val[0] == 0);
                  if (title_on) push_cmd(KIND_TITLE_BEG, 0, 0, 0, 0, 0);
               end
            end
         end
         PM_TITLE: begin
            if (c == CHR_ESC || c == CHR_BEL) begin
               pmode = (c == CHR_ESC) ? PM_STREND : PM_NORMAL;
               if (title_on) begin
                  title_on = 1'b0;
                  push_cmd(KIND_TITLE_END, 0, 0, 0, 0, 0);
               end
            end else if (title_on) push_cmd(KIND_TITLE_CHR, c, 0, 0, 0, 0);
         end
         default: pmode = PM_NORMAL;
      endcase
   endfunction

   // driver: present queued bytes, idle in random bursts
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            decode_byte(req_data_byte);
            n_bytes++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               req_data_byte <= byte_queue.pop_front();
               req_valid <= 1'b1;
               if (idle_enable && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 19);
            end else req_valid <= 1'b0;
         end
      end
   end

   // monitor: check responses, stall in random bursts
   int recv_gap = 0;
   always @(posedge clock) begin
      term_cmd_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            n_cmds++;
            if (cmd_expected.size() == 0) report("unexpected response kind", rsp_kind, 0);
            else begin
               e = cmd_expected.pop_front();
               if (rsp_kind != e.kind) report("kind", rsp_kind, e.kind);
               if (rsp_arg_a != e.arg_a) report("arg_a", rsp_arg_a, e.arg_a);
               if (rsp_arg_b != e.arg_b) report("arg_b", rsp_arg_b, e.arg_b);
               if (rsp_codepoint != e.codepoint) report("codepoint", rsp_codepoint, e.codepoint);
               if (rsp_fore != e.fore) report("fore", rsp_fore, e.fore);
               if (rsp_back != e.back) report("back", rsp_back, e.back);
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= 1'b1;
         end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 18);
            rsp_stall <= 1'b1;
         end else rsp_stall <= 1'b0;
      end
   end

   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
   endtask

   task automatic put_num(input int n);
      put_str($sformatf("%0d", n));
   endtask

   task automatic drain();
      while (byte_queue.size() > 0 || req_valid || cmd_expected.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [3:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_DEFAULT_FORE) dflt_fore = val;
      else dflt_back = val;
      csr_valid <= 1'b0;
   endtask

   // one random sequence, bit of text or noise byte
   task automatic put_random();
      string finals;
      int n;
      finals = "ABCDEFGHfJKXmnc%zm";
      case ($urandom_range(0, 9))
         0, 1: begin
            put_str("\033[");
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
               if (i > 0) put_str(";");
               case ($urandom_range(0, 5))
                  0: ;
                  1: put_num($urandom_range(0, 9));
                  2: put_num($urandom_range(20, 110));
                  3: begin
                     put_str($urandom_range(0, 1) ? "38;5;" : "48;5;");
                     put_num($urandom_range(0, 300));
                  end
                  4: put_num($urandom_range(0, 70000));
                  default: put_num($urandom_range(0, 3));
               endcase
            end
            byte_queue.push_back(finals[$urandom_range(0, finals.len() - 1)]);
            if (byte_queue[$] == "%") byte_queue.push_back(8'($urandom));
         end
         2: begin
            put_str("\033[?");
            case ($urandom_range(0, 4))
               0: put_num(25);
               1: put_num(2004);
               2: put_num(7);
               3: put_num(1004);
               default: put_num($urandom_range(0, 3000));
            endcase
            byte_queue.push_back($urandom_range(0, 4) == 0 ? "$" : ($urandom_range(0, 1) ? "h" : "l"));
            if (byte_queue[$] == "$") byte_queue.push_back(8'($urandom));
         end
         3: begin
            put_str("\033]");
            put_num($urandom_range(0, 2) == 0 ? 2 : 0);
            put_str(";");
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) byte_queue.push_back(8'($urandom_range(32, 255)));
            if ($urandom_range(0, 1)) put_str("\007");
            else begin put_str("\033"); byte_queue.push_back(8'($urandom)); end
         end
         4: begin
            byte_queue.push_back(8'($urandom_range(8'hC0, 8'hFF)));
            n = byte_queue[$] >= 8'hF0 ? 3 : (byte_queue[$] >= 8'hE0 ? 2 : 1);
            for (int i = 0; i < n; i++) byte_queue.push_back(8'($urandom));
         end
         5: begin
            put_str("\033");
            byte_queue.push_back($urandom_range(0, 2) == 0 ? ">" : ($urandom_range(0, 1) ? "=" : 8'($urandom)));
         end
         6: byte_queue.push_back(8'($urandom));
         default: byte_queue.push_back(8'($urandom_range(32, 126)));
      endcase
   endtask

   initial begin
      model_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: cursor moves, positions, erases, reports, modes
      put_str("A\033[A\033[0B\033[5C\033[65535D\033[E\033[3F\033[G\033[7;9H\033[;f");
      put_str("\033[2J\033[3J\033[K\033[X\033[6n\033[5n\033[c\033>\033=\033[%Z");
      put_str("\033[?25l\033[?2004h\033[?7h\033[?1004l\033[?9h\033[?$Q\033[q");
      // saturating arguments and stack overflow
      put_str("\033[999999A\033[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;18H");
      // colours
      put_str("\033[31;42mx\033[91;103mx\033[22mx\033[38;5;200;48;5;256mx\033[100mx");
      put_str("\033[39;49mx\033[;mx\033[1;2;3;4;5;6;7;8;9;10;11;12;13;14;38;5m");
      put_str("\033[38;5;255;48;5;0mq\033[0m");
      // titles and UTF-8 (including escape mid-character)
      put_str("\033]0;hi\007\033]2;x\033\\\033]0;t\033Z");
      byte_queue.push_back(8'hC3); byte_queue.push_back(8'hA9);
      byte_queue.push_back(8'hE2); byte_queue.push_back(8'h82); byte_queue.push_back(8'hAC);
      byte_queue.push_back(8'hF7); byte_queue.push_back(8'hBF);
      byte_queue.push_back(8'hFF); byte_queue.push_back(8'h00);
      byte_queue.push_back(8'hF0); put_str("\033[A"); byte_queue.push_back(8'h80);
      byte_queue.push_back(8'h80); byte_queue.push_back(8'h80);
      byte_queue.push_back(8'h7F);
      drain();

      // several default colour settings, extremes included
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin write_reg(CSR_DEFAULT_FORE, 4'hF); write_reg(CSR_DEFAULT_BACK, 4'h0); end
            1: begin write_reg(CSR_DEFAULT_FORE, 4'h0); write_reg(CSR_DEFAULT_BACK, 4'hF); end
            2: begin write_reg(CSR_DEFAULT_FORE, 4'($urandom)); write_reg(CSR_DEFAULT_BACK, 4'h5); end
            default: begin write_reg(CSR_DEFAULT_FORE, 4'h7); write_reg(CSR_DEFAULT_BACK, 4'h0); end
         endcase
         put_str("\033[0mx\033[X\033[104mx");
         while (byte_queue.size() < 50) put_random();
         if (phase == 3) begin
            wait (byte_queue.size() < 20);
            idle_enable = 1'b0;
         end
         drain();
      end

      $display("covered %0d bytes and %0d responses across four default colour settings",
               n_bytes, n_cmds);
      if (n_errors == 0) $display("[ansi_escape_sequence_decoder_top] OK");
      else $display("[ansi_escape_sequence_decoder_top] ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("[ansi_escape_sequence_decoder_top] ERROR");
      $finish;
   end

endmodule
